// File: rtl/mandelbrot_escape_iterator_top_macros.svh
`ifndef MANDELBROT_ESCAPE_ITERATOR_TOP_MACROS_SVH
`define MANDELBROT_ESCAPE_ITERATOR_TOP_MACROS_SVH

// same-cycle implication
`define MEI_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define MEI_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/mei_pkg.sv
package mei_pkg;

   localparam int WORD_WIDTH  = 32;
   localparam int FRAC_BITS   = 28;
   localparam int COUNT_WIDTH = 16;
   localparam int SQ_WIDTH    = 2 * WORD_WIDTH - FRAC_BITS;

   typedef logic signed [WORD_WIDTH-1:0] word_type;
   typedef logic [WORD_WIDTH-1:0]        mag_type;
   typedef logic [SQ_WIDTH-1:0]          sq_type;
   typedef logic [SQ_WIDTH:0]            sq_sum_type;
   typedef logic [COUNT_WIDTH-1:0]       count_type;

   localparam word_type WORD_MAX = {1'b0, {(WORD_WIDTH-1){1'b1}}};
   localparam word_type WORD_MIN = {1'b1, {(WORD_WIDTH-1){1'b0}}};
   localparam sq_type SQ_WORD_MAX = {{(SQ_WIDTH-WORD_WIDTH){1'b0}}, WORD_MAX};
   localparam sq_sum_type ESC_LIMIT = sq_sum_type'(64'd4 << FRAC_BITS);
   localparam count_type MAX_ITER_RESET = 16'd400;

   typedef struct packed {
      count_type escape_count;
      logic      escaped;
      word_type  z_real;
      word_type  z_imag;
   } result_type;

   typedef struct packed {
      logic idle;
      logic done;
   } seq_status_type;

endpackage

// File: rtl/mei_mul.sv
module mei_mul import mei_pkg::*; (
   input  logic     clock,
   input  word_type op_a,
   input  word_type op_b,
   output sq_type   prod_ff,
   output logic     neg_ff
);

   mag_type                     mag_a;
   mag_type                     mag_b;
   logic [2*WORD_WIDTH-1:0]     full;
   sq_type                      prod_in;
   logic                        neg_in;

   always_comb begin
      mag_a   = op_a[WORD_WIDTH-1] ? mag_type'(-op_a) : mag_type'(op_a);
      mag_b   = op_b[WORD_WIDTH-1] ? mag_type'(-op_b) : mag_type'(op_b);
      full    = mag_a * mag_b;
      prod_in = full[2*WORD_WIDTH-1:FRAC_BITS];
      neg_in  = op_a[WORD_WIDTH-1] ^ op_b[WORD_WIDTH-1];
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      neg_ff  <= neg_in;
   end

endmodule

// File: rtl/mei_seq.sv
module mei_seq import mei_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  word_type       c_real,
   input  word_type       c_imag,
   input  count_type      max_iter,
   input  logic           out_free,
   output seq_status_type status,
   output result_type     result
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_MULP  = 3'd1;
   localparam logic [2:0] ST_FORMP = 3'd2;
   localparam logic [2:0] ST_UPDI  = 3'd3;
   localparam logic [2:0] ST_SQI   = 3'd4;
   localparam logic [2:0] ST_DONE  = 3'd5;

   logic [2:0] state_ff, state_in;
   count_type  iter_ff, iter_in;
   word_type   cr_ff, cr_in;
   word_type   ci_ff, ci_in;
   word_type   zr_ff, zr_in;
   word_type   zi_ff, zi_in;
   word_type   d_ff, d_in;
   word_type   p_ff, p_in;
   sq_type     sq_a_ff, sq_a_in;
   result_type result_ff, result_in;

   word_type   op_a;
   word_type   op_b;
   sq_type     prod_ff;
   logic       neg_ff;
   sq_type     sq_b;
   sq_sum_type sq_sum;
   logic       escape;

   function automatic word_type sat_sq(sq_type m);
      if (m > SQ_WORD_MAX) return WORD_MAX;
      return word_type'(m[WORD_WIDTH-1:0]);
   endfunction

   function automatic word_type sat_prod(sq_type m, logic neg);
      word_type mw;
      mw = word_type'(m[WORD_WIDTH-1:0]);
      if (m > SQ_WORD_MAX) return neg ? WORD_MIN : WORD_MAX;
      return neg ? -mw : mw;
   endfunction

   function automatic word_type sat_add(word_type a, word_type b);
      logic [WORD_WIDTH:0] s;
      s = {a[WORD_WIDTH-1], a} + {b[WORD_WIDTH-1], b};
      if (s[WORD_WIDTH] != s[WORD_WIDTH-1]) return s[WORD_WIDTH] ? WORD_MIN : WORD_MAX;
      return word_type'(s[WORD_WIDTH-1:0]);
   endfunction

   function automatic word_type sat_dbl(word_type a);
      if (a[WORD_WIDTH-1] != a[WORD_WIDTH-2]) return a[WORD_WIDTH-1] ? WORD_MIN : WORD_MAX;
      return {a[WORD_WIDTH-2:0], 1'b0};
   endfunction

   mei_mul u_mul (
      .clock   (clock),
      .op_a    (op_a),
      .op_b    (op_b),
      .prod_ff (prod_ff),
      .neg_ff  (neg_ff)
   );

   always_comb begin
      sq_b   = (iter_ff == '0) ? '0 : prod_ff;
      sq_sum = {1'b0, sq_a_ff} + {1'b0, sq_b};
      escape = (iter_ff != '0) && (sq_sum > ESC_LIMIT);
   end

   always_comb begin
      state_in  = state_ff;
      iter_in   = iter_ff;
      cr_in     = cr_ff;
      ci_in     = ci_ff;
      zr_in     = zr_ff;
      zi_in     = zi_ff;
      d_in      = d_ff;
      p_in      = p_ff;
      sq_a_in   = sq_a_ff;
      result_in = result_ff;
      op_a      = zr_ff;
      op_b      = zi_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cr_in    = c_real;
               ci_in    = c_imag;
               zr_in    = '0;
               zi_in    = '0;
               sq_a_in  = '0;
               iter_in  = '0;
               state_in = ST_MULP;
            end
         end
         ST_MULP: begin
            if (escape) begin
               result_in.escape_count = iter_ff - count_type'(1);
               result_in.escaped      = 1'b1;
               result_in.z_real       = zr_ff;
               result_in.z_imag       = zi_ff;
               state_in               = ST_DONE;
            end else if (iter_ff == max_iter) begin
               result_in.escape_count = '0;
               result_in.escaped      = 1'b0;
               result_in.z_real       = zr_ff;
               result_in.z_imag       = zi_ff;
               state_in               = ST_DONE;
            end else begin
               d_in     = sat_sq(sq_a_ff) - sat_sq(sq_b);
               state_in = ST_FORMP;
            end
         end
         ST_FORMP: begin
            p_in     = sat_prod(prod_ff, neg_ff);
            zr_in    = sat_add(d_ff, cr_ff);
            state_in = ST_UPDI;
         end
         ST_UPDI: begin
            zi_in    = sat_add(sat_dbl(p_ff), ci_ff);
            op_a     = zr_ff;
            op_b     = zr_ff;
            iter_in  = iter_ff + count_type'(1);
            state_in = ST_SQI;
         end
         ST_SQI: begin
            sq_a_in  = prod_ff;
            op_a     = zi_ff;
            op_b     = zi_ff;
            state_in = ST_MULP;
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      iter_ff   <= iter_in;
      cr_ff     <= cr_in;
      ci_ff     <= ci_in;
      zr_ff     <= zr_in;
      zi_ff     <= zi_in;
      d_ff      <= d_in;
      p_ff      <= p_in;
      sq_a_ff   <= sq_a_in;
      result_ff <= result_in;
   end

   assign status.idle = (state_ff == ST_IDLE);
   assign status.done = (state_ff == ST_DONE);
   assign result      = result_ff;

endmodule

// File: rtl/mandelbrot_escape_iterator_top.sv
// Accepts one word at a time: req_ready is high only while the sequencer is idle, so a
// new word waits until the previous result has been passed to the output register.
// Each iteration steps through the MULP, FORMP, UPDI and SQI states and forms
// three products on the single shared 32x32 multiplier.
// Reset: synchronous, active high; clears the sequencer and output valid and
// loads max_iterations with 400.
module mandelbrot_escape_iterator_top import mei_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      req_valid,
   output logic      req_ready,
   input  word_type  req_c_real,
   input  word_type  req_c_imag,
   output logic      rsp_valid,
   input  logic      rsp_ready,
   output count_type rsp_escape_count,
   output logic      rsp_escaped,
   output word_type  rsp_z_real_out,
   output word_type  rsp_z_imag_out,
   input  logic      csr_valid,
   output logic      csr_ready,
   input  count_type csr_max_iterations
);

   count_type      max_iter_ff, max_iter_in;
   logic           rsp_valid_ff, rsp_valid_in;
   result_type     rsp_data_ff, rsp_data_in;
   seq_status_type seq_status;
   result_type     seq_result;
   logic           start;
   logic           out_free;
   logic           load;

   assign start    = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign load     = seq_status.done && out_free;

   mei_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .c_real   (req_c_real),
      .c_imag   (req_c_imag),
      .max_iter (max_iter_ff),
      .out_free (out_free),
      .status   (seq_status),
      .result   (seq_result)
   );

   always_comb begin
      max_iter_in  = csr_valid ? csr_max_iterations : max_iter_ff;
      rsp_valid_in = load || (rsp_valid_ff && !rsp_ready);
      rsp_data_in  = load ? seq_result : rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_iter_ff  <= MAX_ITER_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         max_iter_ff  <= max_iter_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign req_ready        = seq_status.idle;
   assign csr_ready        = 1'b1;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_escape_count = rsp_data_ff.escape_count;
   assign rsp_escaped      = rsp_data_ff.escaped;
   assign rsp_z_real_out   = rsp_data_ff.z_real;
   assign rsp_z_imag_out   = rsp_data_ff.z_imag;

endmodule

// File: rtl/mei_checker.sv
`include "mandelbrot_escape_iterator_top_macros.svh"

module mei_checker import mei_pkg::*; (
   input logic      clock,
   input logic      reset,
   input logic      req_valid,
   input logic      req_ready,
   input logic      rsp_valid,
   input logic      rsp_ready,
   input count_type rsp_escape_count,
   input logic      rsp_escaped,
   input word_type  rsp_z_real_out,
   input word_type  rsp_z_imag_out
);

   `MEI_ASSERT_IMPL(a_bounded_count_zero, clock, reset,
      rsp_valid && !rsp_escaped, rsp_escape_count == '0, "bounded point with nonzero count")
   `MEI_ASSERT_NEXT(a_busy_after_accept, clock, reset,
      req_valid && req_ready, !req_ready, "ready held after accepting a word")
   `MEI_ASSERT_NEXT(a_no_early_result, clock, reset,
      req_valid && req_ready, !$rose(rsp_valid), "result too soon after accept")
   `MEI_ASSERT_NEXT(a_rsp_hold, clock, reset,
      rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_z_real_out) && $stable(rsp_z_imag_out) &&
      $stable(rsp_escape_count), "stalled result changed")

endmodule

bind mandelbrot_escape_iterator_top mei_checker u_mei_checker (.*);

// File: test/mei_escape_checker.sv
module mei_escape_checker import mei_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      req_valid,
   input  logic      req_ready,
   input  word_type  req_c_real,
   input  word_type  req_c_imag,
   input  logic      rsp_valid,
   input  logic      rsp_ready,
   input  count_type rsp_escape_count,
   input  logic      rsp_escaped,
   input  word_type  rsp_z_real_out,
   input  word_type  rsp_z_imag_out,
   input  logic      csr_valid,
   input  logic      csr_ready,
   input  count_type csr_max_iterations,
   output int        mismatch_count,
   output int        points_in_flight
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint unsigned ESCAPE_BOUND = 64'd4 << FRAC_BITS;

   count_type  iter_limit;
   result_type escape_results[$];

   function automatic longint clamp_word(input longint v);
      if (v > longint'(WORD_MAX)) return longint'(WORD_MAX);
      if (v < longint'(WORD_MIN)) return longint'(WORD_MIN);
      return v;
   endfunction

   function automatic longint unsigned mag_product(input longint a, input longint b);
      longint unsigned ma;
      longint unsigned mb;
      ma = (a < 0) ? -a : a;
      mb = (b < 0) ? -b : b;
      return (ma * mb) >> FRAC_BITS;
   endfunction

   function automatic longint fixed_mul(input longint a, input longint b);
      longint m;
      m = longint'(mag_product(a, b));
      if ((a < 0) != (b < 0)) m = -m;
      return clamp_word(m);
   endfunction

   function automatic result_type iterate_point(input word_type c_re, input word_type c_im,
                                                input count_type limit);
      result_type      r;
      longint          zr;
      longint          zi;
      longint          nr;
      longint          ni;
      longint          p;
      longint unsigned mag2;
      int unsigned     step;
      r  = '0;
      zr = 0;
      zi = 0;
      for (step = 0; step < limit && !r.escaped; step++) begin
         p    = fixed_mul(zr, zi);
         nr   = clamp_word(clamp_word(fixed_mul(zr, zr) - fixed_mul(zi, zi)) + longint'(c_re));
         ni   = clamp_word(clamp_word(p + p) + longint'(c_im));
         zr   = nr;
         zi   = ni;
         mag2 = mag_product(zr, zr) + mag_product(zi, zi);
         if (mag2 > ESCAPE_BOUND) begin
            r.escaped      = 1'b1;
            r.escape_count = count_type'(step);
         end
      end
      r.z_real = word_type'(zr);
      r.z_imag = word_type'(zi);
      return r;
   endfunction

   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         iter_limit     = MAX_ITER_RESET;
         mismatch_count = 0;
         escape_results.delete();
      end else begin
         if (req_valid && req_ready)
            escape_results.push_back(iterate_point(req_c_real, req_c_imag, iter_limit));
         if (csr_valid && csr_ready)
            iter_limit = csr_max_iterations;
         if (rsp_valid && rsp_ready) begin
            if (escape_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch at %0t: unexpected result word count=%0d esc=%0b re=%h im=%h",
                           $time, rsp_escape_count, rsp_escaped, rsp_z_real_out,
                           rsp_z_imag_out);
            end else begin
               want = escape_results.pop_front();
               if (rsp_escape_count !== want.escape_count || rsp_escaped !== want.escaped ||
                   rsp_z_real_out !== want.z_real || rsp_z_imag_out !== want.z_imag) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $write("mismatch at %0t: expected count=%0d esc=%0b re=%h im=%h,",
                            $time, want.escape_count, want.escaped, want.z_real,
                            want.z_imag);
                     $display(" got count=%0d esc=%0b re=%h im=%h",
                              rsp_escape_count, rsp_escaped, rsp_z_real_out,
                              rsp_z_imag_out);
                  end
               end
            end
         end
      end
      points_in_flight <= escape_results.size();
   end

endmodule

// File: test/tb_mandelbrot_escape_iterator_top.sv
module tb_mandelbrot_escape_iterator_top;
   timeunit 1ns;
   timeprecision 1ps;
   import mei_pkg::*;

   localparam word_type ONE_Q   = word_type'(1 << FRAC_BITS);
   localparam word_type TWO_Q   = word_type'(2 << FRAC_BITS);
   localparam word_type NEG_TWO = word_type'(-(2 << FRAC_BITS));
   localparam int       ITEM_TARGET = 1500;

   logic      clock              = 1'b0;
   logic      reset              = 1'b1;
   logic      req_valid          = 1'b0;
   logic      req_ready;
   word_type  req_c_real         = '0;
   word_type  req_c_imag         = '0;
   logic      rsp_valid;
   logic      rsp_ready          = 1'b0;
   count_type rsp_escape_count;
   logic      rsp_escaped;
   word_type  rsp_z_real_out;
   word_type  rsp_z_imag_out;
   logic      csr_valid          = 1'b0;
   logic      csr_ready;
   count_type csr_max_iterations = '0;

   int mismatch_count;
   int points_in_flight;
   int points_sent     = 0;
   int rsp_hold_cycles = 0;
   bit idling          = 1'b1;

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   mandelbrot_escape_iterator_top u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_c_real         (req_c_real),
      .req_c_imag         (req_c_imag),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_escape_count   (rsp_escape_count),
      .rsp_escaped        (rsp_escaped),
      .rsp_z_real_out     (rsp_z_real_out),
      .rsp_z_imag_out     (rsp_z_imag_out),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_max_iterations (csr_max_iterations)
   );

   mei_escape_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_c_real         (req_c_real),
      .req_c_imag         (req_c_imag),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_escape_count   (rsp_escape_count),
      .rsp_escaped        (rsp_escaped),
      .rsp_z_real_out     (rsp_z_real_out),
      .rsp_z_imag_out     (rsp_z_imag_out),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_max_iterations (csr_max_iterations),
      .mismatch_count     (mismatch_count),
      .points_in_flight   (points_in_flight)
   );

   function automatic word_type corner_value();
      case ($urandom_range(7, 0))
         0: return WORD_MAX;
         1: return WORD_MIN;
         2: return '0;
         3: return word_type'(-1);
         4: return word_type'(1);
         5: return TWO_Q;
         6: return NEG_TWO;
         default: return word_type'(ONE_Q >>> 2);
      endcase
   endfunction

   task automatic pick_point(output word_type cr, output word_type ci);
      int unsigned sel;
      sel = $urandom_range(99, 0);
      if (sel < 20) begin
         cr = word_type'($urandom);
         ci = word_type'($urandom);
      end else if (sel < 70) begin
         cr = word_type'(int'($urandom_range(805306368, 0)) - 603979776);
         ci = word_type'(int'($urandom_range(805306368, 0)) - 402653184);
      end else if (sel < 85) begin
         cr = word_type'($urandom) >>> $urandom_range(31, 4);
         ci = word_type'($urandom) >>> $urandom_range(31, 4);
      end else begin
         cr = corner_value();
         ci = corner_value();
      end
   endtask

   // escapes on the first update whenever the limit is nonzero
   task automatic pick_far_point(output word_type cr, output word_type ci);
      cr = word_type'(536870913 + int'($urandom_range(1610612734, 0)));
      if ($urandom_range(1, 0)) cr = -cr;
      ci = word_type'($urandom);
   endtask

   task automatic offer_point(input word_type cr, input word_type ci);
      int gap;
      gap = idling ? $urandom_range(17, 0) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_c_real <= cr;
      req_c_imag <= ci;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      points_sent++;
   endtask

   task automatic drain_points();
      req_valid <= 1'b0;
      do @(posedge clock); while (points_in_flight != 0);
   endtask

   task automatic set_iter_limit(input count_type limit);
      drain_points();
      csr_valid          <= 1'b1;
      csr_max_iterations <= limit;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   // result side: random stall per word while idling, or one long hold when requested
   initial begin
      int stall;
      while (reset) @(posedge clock);
      forever begin
         if (rsp_hold_cycles > 0) begin
            stall           = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end else begin
            stall = idling ? $urandom_range(17, 0) : 0;
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   initial begin
      word_type  cr;
      word_type  ci;
      count_type limit;
      int        phase_len;
      int        phase;
      int        k;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      offer_point('0, '0);
      offer_point(WORD_MAX, WORD_MAX);
      offer_point(WORD_MIN, WORD_MIN);
      offer_point(WORD_MAX, WORD_MIN);
      offer_point(WORD_MIN, WORD_MAX);
      offer_point(NEG_TWO, '0);
      offer_point(NEG_TWO - 1, '0);
      offer_point(TWO_Q, '0);
      offer_point('0, ONE_Q);
      offer_point('0, NEG_TWO);
      offer_point(-ONE_Q, '0);
      offer_point(ONE_Q >>> 2, '0);
      offer_point(ONE_Q, '0);
      offer_point(word_type'(1), word_type'(-1));

      set_iter_limit('0);
      for (k = 0; k < 6; k++) begin
         pick_point(cr, ci);
         offer_point(cr, ci);
      end

      set_iter_limit(16'hFFFF);
      offer_point(ONE_Q, '0);
      offer_point(TWO_Q, '0);
      offer_point(NEG_TWO - 1, word_type'($urandom));
      for (k = 0; k < 8; k++) begin
         pick_far_point(cr, ci);
         offer_point(cr, ci);
      end

      set_iter_limit(16'd1);
      for (k = 0; k < 30; k++) begin
         pick_point(cr, ci);
         offer_point(cr, ci);
      end

      // back up the block behind a stalled result channel
      set_iter_limit(16'd12);
      idling          = 1'b0;
      rsp_hold_cycles = 400;
      for (k = 0; k < 12; k++) begin
         pick_point(cr, ci);
         offer_point(cr, ci);
      end

      phase = 0;
      while (points_sent < ITEM_TARGET) begin
         if (phase == 0 || $urandom_range(9, 0) == 0) begin
            limit     = MAX_ITER_RESET;
            phase_len = 30;
         end else begin
            limit     = count_type'($urandom_range(48, 2));
            phase_len = $urandom_range(150, 60);
         end
         set_iter_limit(limit);
         idling = ($urandom_range(3, 0) != 0);
         for (k = 0; k < phase_len && points_sent < ITEM_TARGET; k++) begin
            pick_point(cr, ci);
            offer_point(cr, ci);
         end
         phase++;
      end

      drain_points();
      repeat (50) @(posedge clock);
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   initial begin
      #100ms;
      $display("Mismatches found");
      $finish;
   end

endmodule
